### design/bftm_pkg.sv
`default_nettype none

package bftm_pkg;

  // Sizes
  localparam int unsigned TAPE_CELLS  = 32;
  localparam int unsigned TAPE_AW     = $clog2(TAPE_CELLS);
  localparam int unsigned PROG_DEPTH  = 256;
  localparam int unsigned PROG_AW     = $clog2(PROG_DEPTH);
  localparam int unsigned PC_W        = $clog2(PROG_DEPTH + 1);
  localparam int unsigned BAL_W       = PC_W + 1;

  // Item modes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_STEP   = 2'd2;
  localparam logic [1:0] MODE_NOP    = 2'd3;

  // Program symbols
  localparam logic [7:0] CH_LT    = 8'h3C;  // <
  localparam logic [7:0] CH_GT    = 8'h3E;  // >
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // +
  localparam logic [7:0] CH_MINUS = 8'h2D;  // -
  localparam logic [7:0] CH_DOT   = 8'h2E;  // .
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ,
  localparam logic [7:0] CH_LBR   = 8'h5B;  // [
  localparam logic [7:0] CH_RBR   = 8'h5D;  // ]

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] symbol;
    logic [7:0] input_byte;
  } in_beat_t;

  typedef struct packed {
    logic               out_valid;
    logic [7:0]         out_byte;
    logic               used_input;
    logic               finished;
    logic               unbalanced;
    logic [TAPE_AW-1:0] tape_pointer;
    logic [7:0]         cell_value;
    logic [PC_W-1:0]    program_counter;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_REPORT
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic accept;
    logic clear;
    logic append;
    logic set_unbal;
    logic set_fin;
    logic exec;
    logic scan;
    logic load_out;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [1:0] in_mode;
    logic       unbal;
    logic       at_end;
    logic       need_scan;
    logic       scan_done;
    logic       out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### design/bftm_ctrl.sv
`default_nettype none

module bftm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire bftm_pkg::dp_status_t status_i,
  output bftm_pkg::dp_cmd_t         cmd_o
);

  bftm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bftm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bftm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.in_mode == bftm_pkg::MODE_STEP && !status_i.unbal &&
              !status_i.at_end) begin
            state_d = bftm_pkg::ST_EXEC;
          end else begin
            state_d = bftm_pkg::ST_REPORT;
          end
        end
      end
      bftm_pkg::ST_EXEC: begin
        state_d = status_i.need_scan ? bftm_pkg::ST_SCAN : bftm_pkg::ST_REPORT;
      end
      bftm_pkg::ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = bftm_pkg::ST_REPORT;
        end
      end
      bftm_pkg::ST_REPORT: begin
        if (status_i.out_free) begin
          state_d = bftm_pkg::ST_IDLE;
        end
      end
      default: state_d = bftm_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      bftm_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        cmd_o.clear  = in_valid_i && status_i.in_mode == bftm_pkg::MODE_CLEAR;
        cmd_o.append = in_valid_i && status_i.in_mode == bftm_pkg::MODE_APPEND;
        cmd_o.set_unbal = in_valid_i && status_i.in_mode == bftm_pkg::MODE_STEP &&
                          status_i.unbal;
        cmd_o.set_fin   = in_valid_i && status_i.in_mode == bftm_pkg::MODE_STEP &&
                          !status_i.unbal && status_i.at_end;
      end
      bftm_pkg::ST_EXEC:   cmd_o.exec = 1'b1;
      bftm_pkg::ST_SCAN:   cmd_o.scan = 1'b1;
      bftm_pkg::ST_REPORT: cmd_o.load_out = status_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### design/bftm_dp.sv
`default_nettype none

module bftm_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bftm_pkg::in_beat_t   in_data_i,
  input  wire logic                 out_stall_i,
  output logic                      out_valid_o,
  output bftm_pkg::out_beat_t       out_data_o,
  input  wire bftm_pkg::dp_cmd_t    cmd_i,
  output bftm_pkg::dp_status_t      status_o
);

  localparam int unsigned AW  = bftm_pkg::PROG_AW;
  localparam int unsigned PW  = bftm_pkg::PC_W;
  localparam int unsigned TW  = bftm_pkg::TAPE_AW;
  localparam logic signed [bftm_pkg::BAL_W-1:0] BAL_ONE = bftm_pkg::BAL_W'(1);

  typedef struct packed {
    logic       print;
    logic [7:0] pbyte;
    logic       used;
    logic       fin;
    logic       unbal;
  } flags_t;

  // Program memory, registered read
  logic [7:0]    prog_mem [bftm_pkg::PROG_DEPTH];
  logic [7:0]    instr_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  // Architectural state
  logic [PW-1:0]           len_q, len_d;
  logic [PW-1:0]           pc_q, pc_d;
  logic signed [bftm_pkg::BAL_W-1:0] bal_q, bal_d;
  logic [TW-1:0]           ptr_q, ptr_d;
  logic [7:0]              tape_q [bftm_pkg::TAPE_CELLS];

  // Per-item and scan state
  logic [7:0]    ibyte_q;
  flags_t        flags_q, flags_d;
  logic [AW-1:0] k_q, k_d;
  logic [PW-1:0] depth_q, depth_d;
  logic          fwd_q, fwd_d;

  logic          tape_we;
  logic [7:0]    tape_wdata;
  logic [7:0]    cur_cell;
  logic [PW-1:0] pc_inc;
  logic [PW-1:0] k_inc;
  logic          found;
  logic          need_scan;
  logic          scan_done;

  bftm_pkg::out_beat_t out_q;
  logic                out_full_q;

  assign cur_cell = tape_q[ptr_q];
  assign pc_inc   = pc_q + 1'b1;
  assign k_inc    = {1'b0, k_q} + 1'b1;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prog_mem[len_q[AW-1:0]] <= in_data_i.symbol;
    end
    instr_q <= prog_mem[rd_addr];
  end

  always_comb begin
    len_d      = len_q;
    pc_d       = pc_q;
    bal_d      = bal_q;
    ptr_d      = ptr_q;
    flags_d    = flags_q;
    k_d        = k_q;
    depth_d    = depth_q;
    fwd_d      = fwd_q;
    tape_we    = 1'b0;
    tape_wdata = cur_cell;
    mem_we     = 1'b0;
    need_scan  = 1'b0;
    scan_done  = 1'b0;
    found      = 1'b0;
    rd_addr    = pc_q[AW-1:0];

    if (cmd_i.accept) begin
      flags_d       = '0;
      flags_d.unbal = cmd_i.set_unbal;
      flags_d.fin   = cmd_i.set_fin;
    end

    if (cmd_i.clear) begin
      len_d = '0;
      pc_d  = '0;
      bal_d = '0;
    end

    // Full store drops the symbol, balance untouched
    if (cmd_i.append && len_q < PW'(bftm_pkg::PROG_DEPTH)) begin
      mem_we = 1'b1;
      len_d  = len_q + 1'b1;
      if (in_data_i.symbol == bftm_pkg::CH_LBR) begin
        bal_d = bal_q + BAL_ONE;
      end else if (in_data_i.symbol == bftm_pkg::CH_RBR) begin
        bal_d = bal_q - BAL_ONE;
      end
    end

    if (cmd_i.exec) begin
      pc_d = pc_inc;
      case (instr_q)
        bftm_pkg::CH_LT: begin
          ptr_d = (ptr_q == '0) ? TW'(bftm_pkg::TAPE_CELLS - 1) : ptr_q - 1'b1;
        end
        bftm_pkg::CH_GT: begin
          ptr_d = (ptr_q == TW'(bftm_pkg::TAPE_CELLS - 1)) ? '0 : ptr_q + 1'b1;
        end
        bftm_pkg::CH_PLUS: begin
          tape_we    = 1'b1;
          tape_wdata = cur_cell + 8'd1;
        end
        bftm_pkg::CH_MINUS: begin
          tape_we    = 1'b1;
          tape_wdata = cur_cell - 8'd1;
        end
        bftm_pkg::CH_DOT: begin
          flags_d.print = 1'b1;
          flags_d.pbyte = cur_cell;
        end
        bftm_pkg::CH_COMMA: begin
          flags_d.used = 1'b1;
          tape_we      = 1'b1;
          tape_wdata   = ibyte_q;
        end
        bftm_pkg::CH_LBR: begin
          if (cur_cell == 8'd0 && pc_inc < len_q) begin
            need_scan = 1'b1;
            pc_d      = pc_q;
            k_d       = pc_inc[AW-1:0];
            rd_addr   = pc_inc[AW-1:0];
            depth_d   = '0;
            fwd_d     = 1'b1;
          end
        end
        bftm_pkg::CH_RBR: begin
          if (cur_cell != 8'd0 && pc_q != '0) begin
            need_scan = 1'b1;
            pc_d      = pc_q;
            k_d       = pc_q[AW-1:0] - 1'b1;
            rd_addr   = pc_q[AW-1:0] - 1'b1;
            depth_d   = '0;
            fwd_d     = 1'b0;
          end
        end
        default: ;
      endcase
    end

    // One program entry per cycle, depth tracks nesting
    if (cmd_i.scan) begin
      if (instr_q == (fwd_q ? bftm_pkg::CH_LBR : bftm_pkg::CH_RBR)) begin
        depth_d = depth_q + 1'b1;
      end else if (instr_q == (fwd_q ? bftm_pkg::CH_RBR : bftm_pkg::CH_LBR)) begin
        if (depth_q == '0) begin
          found = 1'b1;
        end else begin
          depth_d = depth_q - 1'b1;
        end
      end
      if (found) begin
        pc_d      = k_inc;
        scan_done = 1'b1;
      end else if (fwd_q) begin
        if (k_inc >= len_q) begin
          pc_d      = pc_inc;
          scan_done = 1'b1;
        end else begin
          k_d     = k_inc[AW-1:0];
          rd_addr = k_inc[AW-1:0];
        end
      end else begin
        if (k_q == '0) begin
          pc_d      = pc_inc;
          scan_done = 1'b1;
        end else begin
          k_d     = k_q - 1'b1;
          rd_addr = k_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      pc_q    <= '0;
      bal_q   <= '0;
      ptr_q   <= '0;
      flags_q <= '0;
      fwd_q   <= 1'b0;
      for (int i = 0; i < bftm_pkg::TAPE_CELLS; i++) begin
        tape_q[i] <= '0;
      end
    end else begin
      len_q   <= len_d;
      pc_q    <= pc_d;
      bal_q   <= bal_d;
      ptr_q   <= ptr_d;
      flags_q <= flags_d;
      fwd_q   <= fwd_d;
      if (tape_we) begin
        tape_q[ptr_q] <= tape_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    depth_q <= depth_d;
    if (cmd_i.accept) begin
      ibyte_q <= in_data_i.input_byte;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_full_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_valid       <= flags_q.print;
      out_q.out_byte        <= flags_q.pbyte;
      out_q.used_input      <= flags_q.used;
      out_q.finished        <= flags_q.fin;
      out_q.unbalanced      <= flags_q.unbal;
      out_q.tape_pointer    <= ptr_q;
      out_q.cell_value      <= cur_cell;
      out_q.program_counter <= pc_q;
    end
  end

  assign out_valid_o = out_full_q;
  assign out_data_o  = out_q;

  assign status_o.in_mode   = in_data_i.mode;
  assign status_o.unbal     = (bal_q != '0);
  assign status_o.at_end    = (pc_q >= len_q);
  assign status_o.need_scan = need_scan;
  assign status_o.scan_done = scan_done;
  assign status_o.out_free  = !out_full_q || !out_stall_i;

endmodule

`default_nettype wire

### design/bf_tape_machine_step.sv
// Channel | Direction | Handshake             | Beat
// in      | input     | in_valid_i/in_stall_o  | bftm_pkg::in_beat_t  (mode, symbol, input_byte)
// out     | output    | out_valid_o/out_stall_i| bftm_pkg::out_beat_t (one result per item)
//
// Sequence: clear, append, refused or finished step go from accept straight to report;
// a plain instruction passes through execute first. A bracket whose cell calls for
// a jump adds a scan at one program entry per cycle, partner found or not, since
// the program memory has one registered read port and the scan walks it.
// Reset: tape, pointer, pc, length and bracket balance clear at once; the
// program memory is not cleared, only entries below the length are read.
// The input side stalls while an item is in work; a stalled result holds in
// the output register, and the machine waits in its report state for it.
`default_nettype none

module bf_tape_machine_step (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire bftm_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output bftm_pkg::out_beat_t      out_data_o
);

  bftm_pkg::dp_cmd_t    cmd;
  bftm_pkg::dp_status_t status;

  // Sequencer: accept, instruction execute, bracket scan, report
  bftm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Program memory, tape, pointer/pc and the result register
  bftm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

`default_nettype wire

### design/bftm_checker.sv
`default_nettype none

module bftm_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire bftm_pkg::out_beat_t out_data_o
);

  // A stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // One item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while item in work");

  // At most one outcome flag per result
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_data_o.out_valid, out_data_o.used_input,
                              out_data_o.finished, out_data_o.unbalanced}))
    else $error("conflicting outcome flags");

  // Printed byte is zero unless a print ran
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_valid |-> out_data_o.out_byte == 8'd0)
    else $error("out_byte set without print");

endmodule

bind bf_tape_machine_step bftm_checker u_bftm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

### tb/bf_tape_machine_step_tb.sv
`default_nettype none

module bf_tape_machine_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Random part stops once this many non-idle items have gone in.
  localparam int ITEMS_TARGET = 1450;
  // Sized from the worst item (a full 256-entry bracket scan, a long stall and a long
  // gap) over ~2000 items, taken three times over.
  localparam int CYCLE_LIMIT  = 3_000_000;
  // Quiet cycles after the last result, to catch a stray extra beat.
  localparam int DRAIN_CYCLES = 20;
  // Only the first few mismatches are printed; all are counted.
  localparam int PRINT_CAP    = 40;
  // Widths used in casts.
  localparam int unsigned PTR_W = bftm_pkg::TAPE_AW;
  localparam int unsigned CNT_W = bftm_pkg::PC_W;

  // ---------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  bftm_pkg::in_beat_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bftm_pkg::out_beat_t out_data;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bf_tape_machine_step u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Machine mirror: program memory, pc, bracket balance, tape and pointer.
  // Updated once per accepted input beat.
  // ---------------------------------------------------------------------------
  logic [7:0]       prog_mem [bftm_pkg::PROG_DEPTH];
  logic [CNT_W-1:0] prog_len;
  logic [CNT_W-1:0] prog_pc;
  int               bracket_bal;
  logic [7:0]       tape_mem [bftm_pkg::TAPE_CELLS];
  logic [PTR_W-1:0] tape_ptr;

  // Results still owed by the block, oldest first.
  bftm_pkg::out_beat_t pending_results [$];

  // Run statistics and error tally.
  int n_items;
  int n_programs;
  int n_checked;
  int n_prints;
  int n_reads;
  int n_jumps;
  int n_refused;
  int n_ended;
  int n_errors;
  int cycle_count;

  // Idle/stall enables, redrawn per program so that some stretches run flat out.
  bit idle_on  = 1'b1;
  bit stall_on = 1'b1;
  int stall_left;

  // Plain commands; '+' and '-' weighted up so loops tend to terminate.
  logic [7:0] plain_cmds [8] = '{bftm_pkg::CH_LT, bftm_pkg::CH_GT,
                                 bftm_pkg::CH_PLUS, bftm_pkg::CH_PLUS,
                                 bftm_pkg::CH_MINUS, bftm_pkg::CH_MINUS,
                                 bftm_pkg::CH_DOT, bftm_pkg::CH_COMMA};

  // One input beat through the machine; returns the result it must produce.
  function automatic bftm_pkg::out_beat_t step_machine(bftm_pkg::in_beat_t b);
    bftm_pkg::out_beat_t r;
    logic [CNT_W-1:0]    nxt;
    int                  depth;
    int                  k;
    bit                  hit;
    r     = '0;
    depth = 0;
    hit   = 1'b0;
    case (b.mode)
      bftm_pkg::MODE_CLEAR: begin
        // tape and pointer survive a clear
        prog_len    = '0;
        prog_pc     = '0;
        bracket_bal = 0;
      end
      bftm_pkg::MODE_APPEND: begin
        // full store: symbol dropped, balance untouched
        if (prog_len < bftm_pkg::PROG_DEPTH) begin
          prog_mem[prog_len[bftm_pkg::PROG_AW-1:0]] = b.symbol;
          prog_len++;
          if (b.symbol == bftm_pkg::CH_LBR) bracket_bal++;
          else if (b.symbol == bftm_pkg::CH_RBR) bracket_bal--;
        end
      end
      bftm_pkg::MODE_STEP: begin
        if (bracket_bal != 0) begin
          r.unbalanced = 1'b1;
          n_refused++;
        end else if (prog_pc >= prog_len) begin
          r.finished = 1'b1;
          n_ended++;
        end else begin
          nxt = prog_pc + 1'b1;
          case (prog_mem[prog_pc[bftm_pkg::PROG_AW-1:0]])
            bftm_pkg::CH_LT: begin
              tape_ptr = (tape_ptr == '0) ? PTR_W'(bftm_pkg::TAPE_CELLS - 1)
                                          : tape_ptr - 1'b1;
            end
            bftm_pkg::CH_GT: begin
              tape_ptr = (int'(tape_ptr) + 1 >= bftm_pkg::TAPE_CELLS) ? '0
                                                                     : tape_ptr + 1'b1;
            end
            bftm_pkg::CH_PLUS:  tape_mem[tape_ptr] = tape_mem[tape_ptr] + 8'd1;
            bftm_pkg::CH_MINUS: tape_mem[tape_ptr] = tape_mem[tape_ptr] - 8'd1;
            bftm_pkg::CH_DOT: begin
              r.out_valid = 1'b1;
              r.out_byte  = tape_mem[tape_ptr];
              n_prints++;
            end
            bftm_pkg::CH_COMMA: begin
              r.used_input       = 1'b1;
              tape_mem[tape_ptr] = b.input_byte;
              n_reads++;
            end
            bftm_pkg::CH_LBR: begin
              // zero cell: skip past the nested partner, if there is one
              if (tape_mem[tape_ptr] == 8'd0) begin
                for (k = int'(prog_pc) + 1; k < int'(prog_len) && !hit; k++) begin
                  if (prog_mem[k] == bftm_pkg::CH_LBR) begin
                    depth++;
                  end else if (prog_mem[k] == bftm_pkg::CH_RBR) begin
                    if (depth == 0) begin
                      hit = 1'b1;
                      nxt = CNT_W'(k + 1);
                    end else begin
                      depth--;
                    end
                  end
                end
              end
            end
            bftm_pkg::CH_RBR: begin
              // nonzero cell: back to just after the nested partner
              if (tape_mem[tape_ptr] != 8'd0) begin
                for (k = int'(prog_pc) - 1; k >= 0 && !hit; k--) begin
                  if (prog_mem[k] == bftm_pkg::CH_RBR) begin
                    depth++;
                  end else if (prog_mem[k] == bftm_pkg::CH_LBR) begin
                    if (depth == 0) begin
                      hit = 1'b1;
                      nxt = CNT_W'(k + 1);
                    end else begin
                      depth--;
                    end
                  end
                end
              end
            end
            default: ;
          endcase
          if (hit) n_jumps++;
          prog_pc = nxt;
        end
      end
      default: ;  // idle mode: status only
    endcase
    r.tape_pointer    = tape_ptr;
    r.cell_value      = tape_mem[tape_ptr];
    r.program_counter = prog_pc;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Input byte for a step: zero often, so ',' can set up forward jumps.
  function automatic logic [7:0] step_byte();
    return ($urandom_range(0, 3) == 0) ? 8'h00 : rand_byte();
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and the result checker. Outputs are sampled at the
  // rising edge; a beat moves when valid is high and stall is low.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want_v);
    if (n_errors < PRINT_CAP)
      $display("MISMATCH beat %0d %s: got %0d, want %0d", n_checked, what, got, want_v);
    n_errors++;
  endtask

  task automatic check_field(input string what, input int got, input int want_v);
    if (got != want_v) report_mismatch(what, got, want_v);
  endtask

  bftm_pkg::out_beat_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("beat with nothing owed", 1, 0);
      end else begin
        want = pending_results.pop_front();
        check_field("out_valid",       out_data.out_valid,       want.out_valid);
        check_field("out_byte",        out_data.out_byte,        want.out_byte);
        check_field("used_input",      out_data.used_input,      want.used_input);
        check_field("finished",        out_data.finished,        want.finished);
        check_field("unbalanced",      out_data.unbalanced,      want.unbalanced);
        check_field("tape_pointer",    out_data.tape_pointer,    want.tape_pointer);
        check_field("cell_value",      out_data.cell_value,      want.cell_value);
        check_field("program_counter", out_data.program_counter, want.program_counter);
        n_checked++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed",
               cycle_count, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output backpressure, driven at the falling edge.
  always @(negedge clk) begin
    if (stall_left == 0 && stall_on) stall_left = pick_gap();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Beat sender: optional gap, then hold the beat until accepted. Valid is
  // only lowered at the start of a gap, so it never drops and rises in one step.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [1:0] mode, input logic [7:0] sym,
                           input logic [7:0] ib);
    bftm_pkg::in_beat_t b;
    bftm_pkg::in_beat_t junk;
    int                 gap;
    b.mode       = mode;
    b.symbol     = sym;
    b.input_byte = ib;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      junk.mode       = 2'($urandom_range(0, 3));
      junk.symbol     = rand_byte();
      junk.input_byte = rand_byte();
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= junk;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(step_machine(b));
    if (mode != bftm_pkg::MODE_NOP) n_items++;
  endtask

  task automatic do_step(input logic [7:0] ib);
    send_beat(bftm_pkg::MODE_STEP, rand_byte(), ib);
  endtask

  // ---------------------------------------------------------------------------
  // One program session: build a bracket-balanced program with random body,
  // load it, then step it with a little noise mixed in. Some sessions are
  // broken on purpose (stray bracket) so steps get refused.
  // ---------------------------------------------------------------------------
  task automatic run_program(input int len, input bit keep_old, input int extra);
    logic [7:0] code [$];
    logic [7:0] s;
    int         depth;
    int         steps;
    int         r;
    bit         broken;
    idle_on  = ($urandom_range(0, 3) != 0);
    stall_on = ($urandom_range(0, 3) != 0);
    broken   = (extra == 0) && ($urandom_range(0, 99) < 12);
    depth    = 0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (depth > 0 && len - i <= depth) begin
        s = bftm_pkg::CH_RBR;
        depth--;
      end else if (r < 12 && len - i > depth + 1) begin
        s = bftm_pkg::CH_LBR;
        depth++;
      end else if (r < 24 && depth > 0) begin
        s = bftm_pkg::CH_RBR;
        depth--;
      end else if (r < 28) begin
        // filler symbol, never a bracket
        s = rand_byte();
        if (s == bftm_pkg::CH_LBR || s == bftm_pkg::CH_RBR) s = 8'h20;
      end else begin
        s = plain_cmds[$urandom_range(0, 7)];
      end
      code.push_back(s);
    end
    if (broken && code.size() > 0) begin
      case ($urandom_range(0, 2))
        0:       code[$urandom_range(0, code.size() - 1)] = bftm_pkg::CH_LBR;
        1:       code.push_back(bftm_pkg::CH_RBR);
        default: code.push_back(bftm_pkg::CH_LBR);
      endcase
    end

    n_programs++;
    if (!keep_old) send_beat(bftm_pkg::MODE_CLEAR, rand_byte(), rand_byte());
    foreach (code[i]) send_beat(bftm_pkg::MODE_APPEND, code[i], rand_byte());
    // brackets past a full store must be dropped without touching the balance
    for (int i = 0; i < extra; i++)
      send_beat(bftm_pkg::MODE_APPEND,
                (i % 2 == 0) ? bftm_pkg::CH_LBR : bftm_pkg::CH_RBR, rand_byte());

    steps = $urandom_range(len, 3 * len + 4);
    for (int i = 0; i < steps; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        send_beat(bftm_pkg::MODE_NOP, rand_byte(), rand_byte());
      else if (r < 5)
        send_beat(bftm_pkg::MODE_APPEND, plain_cmds[$urandom_range(0, 7)], rand_byte());
      else if (r < 6)
        send_beat(bftm_pkg::MODE_CLEAR, rand_byte(), rand_byte());
      else
        do_step(step_byte());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Step with nothing loaded: end of program straight away.
  task automatic test_empty_program();
    n_programs++;
    do_step(8'hFF);
  endtask

  // Every plain command once, both pointer wraps and both cell wraps,
  // then a lone '[' to get a refused step.
  task automatic test_plain_commands();
    logic [7:0] seq [6] = '{bftm_pkg::CH_LT, bftm_pkg::CH_MINUS, bftm_pkg::CH_DOT,
                            bftm_pkg::CH_PLUS, bftm_pkg::CH_COMMA, bftm_pkg::CH_GT};
    n_programs++;
    foreach (seq[i]) send_beat(bftm_pkg::MODE_APPEND, seq[i], 8'h00);
    foreach (seq[i]) do_step(8'hA5);
    send_beat(bftm_pkg::MODE_APPEND, bftm_pkg::CH_LBR, 8'hFF);
    do_step(8'h5A);
  endtask

  // Brackets with no nested partner ("][") act as no-ops, on zero and
  // nonzero cells; then run off the end.
  task automatic test_orphan_brackets();
    logic [7:0] seq [6] = '{bftm_pkg::CH_PLUS, bftm_pkg::CH_RBR, bftm_pkg::CH_LBR,
                            bftm_pkg::CH_COMMA, bftm_pkg::CH_RBR, bftm_pkg::CH_LBR};
    n_programs++;
    send_beat(bftm_pkg::MODE_CLEAR, 8'hFF, 8'hFF);
    foreach (seq[i]) send_beat(bftm_pkg::MODE_APPEND, seq[i], 8'h00);
    for (int i = 0; i < 7; i++) do_step(8'h00);
  endtask

  // Fill the whole program store, push brackets past the end, and step it
  // far enough to reach the last entry and long scans.
  task automatic test_full_store();
    run_program(bftm_pkg::PROG_DEPTH, 1'b0, 3);
  endtask

  // Random programs, mostly short, a few long, some unbalanced.
  task automatic test_random_programs();
    int len;
    while (n_items < ITEMS_TARGET) begin
      len = ($urandom_range(0, 99) < 5) ? $urandom_range(60, 200) : $urandom_range(1, 30);
      run_program(len, $urandom_range(0, 9) == 0, 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < bftm_pkg::TAPE_CELLS; i++) tape_mem[i] = '0;
    prog_len    = '0;
    prog_pc     = '0;
    bracket_bal = 0;
    tape_ptr    = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_program();
    test_plain_commands();
    test_orphan_brackets();
    test_full_store();
    test_random_programs();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items over %0d programs, %0d result beats checked in %0d cycles.",
             n_items, n_programs, n_checked, cycle_count);
    $display("Seen: %0d printed, %0d read, %0d jumps, %0d refused, %0d at end.",
             n_prints, n_reads, n_jumps, n_refused, n_ended);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
design/bftm_pkg.sv
design/bftm_ctrl.sv
design/bftm_dp.sv
design/bf_tape_machine_step.sv
design/bftm_checker.sv
tb/bf_tape_machine_step_tb.sv
